// ===== sv/lobm_pkg.sv =====
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

  localparam int QTY_W = 31;
  localparam int ID_W  = 32;
  localparam int TN_W  = 32;

  localparam logic SIDE_BUY     = 1'b0;
  localparam logic SIDE_SELL    = 1'b1;
  localparam logic KIND_LIMIT   = 1'b0;
  localparam logic KIND_MARKET  = 1'b1;

  typedef enum logic [1:0] {
    OUT_FILLED  = 2'd0,
    OUT_RESTED  = 2'd1,
    OUT_DROPPED = 2'd2,
    OUT_FULL    = 2'd3
  } outcome_t;

  localparam int MAX_RESULTS = 64;
  localparam int NRES_W      = 7;

endpackage

// ===== sv/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher.
//  channel | ports                         | direction
//  input   | in_valid/in_ready + order     | in
//  output  | out_valid/out_ready + trade   | out
// Each fill is a scan reading one entry per cycle, a drain and decide step,
// one memory read and one fill; closing an order takes the accept, a final
// scan and the last result. An order of zero quantity goes from the scan
// straight to the close. The input queue registers each order. Reset is
// synchronous, active low, and empties the book. A two-entry queue decouples
// input from the engine; each trade is held until the next one or the close
// is known, and the engine stalls while the result register waits on out_ready.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int BOOK_ENTRIES = 64,
  parameter int PRICE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_side,
  input  logic                  in_order_kind,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic [QTY_W-1:0]      in_quantity,
  input  logic [ID_W-1:0]       in_order_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_trade_valid,
  output logic [TN_W-1:0]       out_trade_number,
  output logic [ID_W-1:0]       out_buyer_id,
  output logic [ID_W-1:0]       out_seller_id,
  output logic [15:0]           out_fill_price,
  output logic [QTY_W-1:0]      out_fill_quantity,
  output logic [1:0]            out_outcome,
  output logic                  out_last
);
  logic q_valid, q_ready, q_side, q_kind;
  logic [PRICE_BITS-1:0] q_price;
  logic [QTY_W-1:0] q_qty;
  logic [ID_W-1:0] q_id;

  lobm_front #(.PW(PRICE_BITS), .DEPTH(2)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_side, .in_kind(in_order_kind),
    .in_price, .in_qty(in_quantity), .in_id(in_order_id),
    .q_valid, .q_ready, .q_side, .q_kind, .q_price, .q_qty, .q_id
  );

  lobm_engine #(.N(BOOK_ENTRIES), .PW(PRICE_BITS)) u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_side, .q_kind, .q_price, .q_qty, .q_id,
    .out_valid, .out_ready, .out_trade_valid, .out_trade_number, .out_buyer_id,
    .out_seller_id, .out_fill_price, .out_fill_quantity, .out_outcome, .out_last
  );
endmodule

// ===== sv/lobm_front.sv =====
// Input side: accept orders into a short queue ahead of the matching engine.
module lobm_front
  import lobm_pkg::*;
#(
  parameter int PW = 16,
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_side,
  input  logic            in_kind,
  input  logic [PW-1:0]   in_price,
  input  logic [QTY_W-1:0] in_qty,
  input  logic [ID_W-1:0] in_id,
  output logic            q_valid,
  input  logic            q_ready,
  output logic            q_side,
  output logic            q_kind,
  output logic [PW-1:0]   q_price,
  output logic [QTY_W-1:0] q_qty,
  output logic [ID_W-1:0] q_id
);
  localparam int W = 2 + PW + QTY_W + ID_W;
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign push = in_valid & in_ready;
  assign pop  = q_valid & q_ready;
  assign {q_side, q_kind, q_price, q_qty, q_id} = mem_r[rp_r];

  // Store transfers and advance pointers
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= {in_side, in_kind, in_price, in_qty, in_id};
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== sv/lobm_engine.sv =====
// Matching engine: scans the book one entry per cycle and emits trades.
module lobm_engine
  import lobm_pkg::*;
#(
  parameter int N  = 64,
  parameter int PW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic             q_side,
  input  logic             q_kind,
  input  logic [PW-1:0]    q_price,
  input  logic [QTY_W-1:0] q_qty,
  input  logic [ID_W-1:0]  q_id,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_trade_valid,
  output logic [TN_W-1:0]  out_trade_number,
  output logic [ID_W-1:0]  out_buyer_id,
  output logic [ID_W-1:0]  out_seller_id,
  output logic [15:0]      out_fill_price,
  output logic [QTY_W-1:0] out_fill_quantity,
  output logic [1:0]       out_outcome,
  output logic             out_last
);
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_RD   = 5'b00100,
    S_FILL = 5'b01000,
    S_DONE = 5'b10000
  } st_t;

  // Book storage: valid and side bits in flops, payload in memories
  logic [N-1:0]     vld_r;
  logic [N-1:0]     eside_r;
  logic [PW-1:0]    eprice_r [N];
  logic [QTY_W-1:0] eqty_mem [N];
  logic [ID_W-1:0]  eid_mem  [N];
  logic [31:0]      eage_r   [N];
  logic [31:0]      arr_r;
  logic [TN_W-1:0]  tn_r;

  st_t st_r;
  logic             side_r, kind_r;
  logic [PW-1:0]    price_r;
  logic [QTY_W-1:0] qty_r;
  logic [ID_W-1:0]  id_r;
  logic [NRES_W-1:0] n_r;
  logic [IW:0]      idx_r;
  logic             rd_v_r;
  logic [IW-1:0]    rd_idx_r;
  logic [PW-1:0]    rd_price_r;
  logic [31:0]      rd_age_r;
  logic             bfound_r;
  logic [IW-1:0]    bidx_r;
  logic [PW-1:0]    bprice_r;
  logic [31:0]      belap_r;
  logic [QTY_W-1:0] rqty_r;
  logic [ID_W-1:0]  rid_r;

  // Trade held back until it is known whether it is the last one
  logic             hv_r;
  logic [TN_W-1:0]  h_tn_r;
  logic [ID_W-1:0]  h_b_r, h_s_r;
  logic [15:0]      h_p_r;
  logic [QTY_W-1:0] h_q_r;

  logic ov_r;
  logic             o_tv_r, o_last_r;
  logic [TN_W-1:0]  o_tn_r;
  logic [ID_W-1:0]  o_b_r, o_s_r;
  logic [15:0]      o_p_r;
  logic [QTY_W-1:0] o_q_r;
  logic [1:0]       o_oc_r;

  assign out_valid = ov_r;
  assign out_trade_valid = o_tv_r;
  assign out_trade_number = o_tn_r;
  assign out_buyer_id = o_b_r;
  assign out_seller_id = o_s_r;
  assign out_fill_price = o_p_r;
  assign out_fill_quantity = o_q_r;
  assign out_outcome = o_oc_r;
  assign out_last = o_last_r;
  assign q_ready = (st_r == S_IDLE);

  logic obuf_free;
  assign obuf_free = !ov_r || out_ready;

  // Scan candidate compare, on the entry read in the previous cycle
  logic [IW-1:0] ci;
  logic [31:0] celap;
  logic cand, cbetter, crosses;
  assign ci = idx_r[IW-1:0];
  assign celap = arr_r - rd_age_r;
  assign cand = rd_v_r && vld_r[rd_idx_r] && (eside_r[rd_idx_r] != side_r);
  always_comb begin
    cbetter = 1'b0;
    if (!bfound_r) cbetter = 1'b1;
    else if (rd_price_r != bprice_r)
      cbetter = side_r ? (rd_price_r > bprice_r) : (rd_price_r < bprice_r);
    else cbetter = celap > belap_r;
  end
  assign crosses = (kind_r == KIND_MARKET) ||
                   (side_r == SIDE_BUY  && !(bprice_r > price_r)) ||
                   (side_r == SIDE_SELL && !(bprice_r < price_r));

  // Free slot search (priority encoder over valid bits)
  logic free_any;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = N-1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Final outcome of the current order
  outcome_t done_oc;
  always_comb begin
    if (qty_r == '0) done_oc = OUT_FILLED;
    else if (kind_r == KIND_MARKET) done_oc = OUT_DROPPED;
    else if (!free_any) done_oc = OUT_FULL;
    else done_oc = OUT_RESTED;
  end

  logic [QTY_W-1:0] fill;
  assign fill = (qty_r < rqty_r) ? qty_r : rqty_r;

  // Load the result register when a held trade is released or the order closes
  logic fill_go, emit;
  assign fill_go = !hv_r || obuf_free;
  assign emit = ((st_r == S_FILL) && hv_r && obuf_free) ||
                ((st_r == S_DONE) && obuf_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      vld_r <= '0;
      arr_r <= '0;
      tn_r <= TN_W'(1);
      ov_r <= 1'b0;
      hv_r <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      ov_r <= emit || (ov_r && !out_ready);
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            side_r <= q_side;
            kind_r <= q_kind;
            price_r <= q_price;
            qty_r <= q_qty;
            id_r <= q_id;
            n_r <= '0;
            idx_r <= '0;
            rd_v_r <= 1'b0;
            bfound_r <= 1'b0;
            st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Track best opposite entry: price first, then oldest
          if (qty_r == '0 || n_r == NRES_W'(MAX_RESULTS)) begin
            st_r <= S_DONE;
          end else if (idx_r == (IW+1)'(N) && !rd_v_r) begin
            if (bfound_r && crosses) st_r <= S_RD;
            else st_r <= S_DONE;
          end else begin
            // Read one entry per cycle, compare the one read last cycle
            if (idx_r != (IW+1)'(N)) begin
              rd_price_r <= eprice_r[ci];
              rd_age_r <= eage_r[ci];
              rd_idx_r <= ci;
              idx_r <= idx_r + (IW+1)'(1);
            end
            rd_v_r <= (idx_r != (IW+1)'(N));
            if (cand && cbetter) begin
              bfound_r <= 1'b1;
              bidx_r <= rd_idx_r;
              bprice_r <= rd_price_r;
              belap_r <= celap;
            end
          end
        end
        S_RD: begin
          rqty_r <= eqty_mem[bidx_r];
          rid_r <= eid_mem[bidx_r];
          st_r <= S_FILL;
        end
        S_FILL: begin
          // Release the held trade, hold this one and update the resting entry
          if (fill_go) begin
            if (hv_r) begin
              o_tv_r <= 1'b1;
              o_tn_r <= h_tn_r;
              o_b_r <= h_b_r;
              o_s_r <= h_s_r;
              o_p_r <= h_p_r;
              o_q_r <= h_q_r;
              o_oc_r <= OUT_FILLED;
              o_last_r <= 1'b0;
            end
            hv_r <= 1'b1;
            h_tn_r <= tn_r;
            h_b_r <= side_r ? rid_r : id_r;
            h_s_r <= side_r ? id_r : rid_r;
            h_p_r <= 16'(bprice_r);
            h_q_r <= fill;
            tn_r <= tn_r + TN_W'(1);
            eqty_mem[bidx_r] <= rqty_r - fill;
            if (rqty_r == fill) vld_r[bidx_r] <= 1'b0;
            qty_r <= qty_r - fill;
            n_r <= n_r + NRES_W'(1);
            idx_r <= '0;
            rd_v_r <= 1'b0;
            bfound_r <= 1'b0;
            st_r <= S_SCAN;
          end
        end
        S_DONE: begin
          // Finish: rest remainder, send the last result
          if (obuf_free) begin
            if (done_oc == OUT_RESTED) begin
              vld_r[free_idx] <= 1'b1;
              eside_r[free_idx] <= side_r;
              eprice_r[free_idx] <= price_r;
              eqty_mem[free_idx] <= qty_r;
              eid_mem[free_idx] <= id_r;
              eage_r[free_idx] <= arr_r;
              arr_r <= arr_r + 32'd1;
            end
            if (hv_r) begin
              o_tv_r <= 1'b1;
              o_tn_r <= h_tn_r;
              o_b_r <= h_b_r;
              o_s_r <= h_s_r;
              o_p_r <= h_p_r;
              o_q_r <= h_q_r;
            end else begin
              o_tv_r <= 1'b0;
              o_tn_r <= '0;
              o_b_r <= '0;
              o_s_r <= '0;
              o_p_r <= '0;
              o_q_r <= '0;
            end
            o_oc_r <= done_oc;
            o_last_r <= 1'b1;
            hv_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/lobm_checker.sv =====
// Port-level checks for the matcher, bound to the top level.
module lobm_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_trade_valid,
  input logic [31:0] out_trade_number,
  input logic [1:0] out_outcome,
  input logic out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_trade_number))
    else $error("output changed while stalled");
  a_oc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_outcome == 2'd0)
    else $error("outcome on non-final result");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_trade_valid |-> out_last && out_trade_number == 32'd0)
    else $error("status result malformed");
endmodule

bind limit_order_book_matcher lobm_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_trade_valid, .out_trade_number,
  .out_outcome, .out_last
);
